[hdl/pwsd_pkg.sv]
// ----------------------------------------------------------------------------
// pwsd_pkg
// Shared widths, codes, reset values and types of the pulse width serial
// decoder.
// ----------------------------------------------------------------------------
package pwsd_pkg;

  // Field widths.
  localparam int unsigned LenW   = 24;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DirW   = 2;
  localparam int unsigned CountW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_ERROR     = 3'd0;
  localparam logic [KindW-1:0] KIND_SYNC      = 3'd1;
  localparam logic [KindW-1:0] KIND_OUT_START = 3'd2;
  localparam logic [KindW-1:0] KIND_IN_START  = 3'd3;
  localparam logic [KindW-1:0] KIND_DATA      = 3'd4;

  // Transfer directions.
  localparam logic [DirW-1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [DirW-1:0] DIR_OUT     = 2'd1;
  localparam logic [DirW-1:0] DIR_IN      = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OUT_START = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IN_START  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MSB_FIRST = 3'd4;

  // Configuration reset values.
  localparam logic [LenW-1:0] TIMEOUT_RESET   = 24'd300;
  localparam logic [LenW-1:0] SYNC_RESET      = 24'd250;
  localparam logic [LenW-1:0] OUT_START_RESET = 24'd140;
  localparam logic [LenW-1:0] IN_START_RESET  = 24'd70;
  localparam logic            MSB_FIRST_RESET = 1'b1;

  // Last bit position of a byte.
  localparam logic [CountW-1:0] LAST_BIT = 3'd7;

  // Configuration as seen by the decode logic.
  typedef struct packed {
    logic [LenW-1:0] timeout_limit;
    logic [LenW-1:0] sync_limit;
    logic [LenW-1:0] outbound_start_limit;
    logic [LenW-1:0] inbound_start_limit;
    logic            msb_first;
  } cfg_t;

  // Decoder state carried from item to item.
  typedef struct packed {
    logic [CountW-1:0] bit_counter;
    logic [ByteW-1:0]  byte_shift;
    logic [DirW-1:0]   current_direction;
  } state_t;

  // One result item and whether the item produced it.
  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] frame_kind;
    logic [ByteW-1:0] byte_value;
    logic [DirW-1:0]  direction;
  } result_t;

endpackage

[hdl/pwsd_decode.sv]
// ----------------------------------------------------------------------------
// pwsd_decode
// Combinational decode of one pulse: classifies its length against the four
// limits, assembles data bits and yields the next state and the result.
// ----------------------------------------------------------------------------
module pwsd_decode (
  input  pwsd_pkg::cfg_t                 cfg,
  input  pwsd_pkg::state_t               state,
  input  logic [pwsd_pkg::LenW-1:0]      pulse_length,
  input  logic                           data_bit,
  output pwsd_pkg::state_t               state_next,
  output pwsd_pkg::result_t              result
);

  logic [pwsd_pkg::ByteW-1:0] bit_mask;
  logic [pwsd_pkg::ByteW-1:0] byte_merged;

  // Position of the incoming bit in the byte.
  always_comb begin
    if (cfg.msb_first) begin
      bit_mask = 8'h80 >> state.bit_counter;
    end else begin
      bit_mask = 8'h01 << state.bit_counter;
    end
    byte_merged = state.byte_shift | (data_bit ? bit_mask : '0);
  end

  // Classification in fixed priority order; the first limit exceeded wins.
  always_comb begin
    state_next = state;
    result.valid      = 1'b1;
    result.frame_kind = pwsd_pkg::KIND_DATA;
    result.byte_value = '0;
    result.direction  = state.current_direction;

    if (pulse_length > cfg.timeout_limit) begin
      result.frame_kind = pwsd_pkg::KIND_ERROR;
      state_next.current_direction = pwsd_pkg::DIR_UNKNOWN;
    end else if (pulse_length > cfg.sync_limit) begin
      result.frame_kind = pwsd_pkg::KIND_SYNC;
      state_next.current_direction = pwsd_pkg::DIR_UNKNOWN;
    end else if (pulse_length > cfg.outbound_start_limit) begin
      result.frame_kind = pwsd_pkg::KIND_OUT_START;
      state_next.current_direction = pwsd_pkg::DIR_OUT;
    end else if (pulse_length > cfg.inbound_start_limit) begin
      result.frame_kind = pwsd_pkg::KIND_IN_START;
      state_next.current_direction = pwsd_pkg::DIR_IN;
    end

    if (pulse_length > cfg.inbound_start_limit ||
        pulse_length > cfg.outbound_start_limit ||
        pulse_length > cfg.sync_limit ||
        pulse_length > cfg.timeout_limit) begin
      // Any framing pulse restarts the byte.
      state_next.bit_counter = '0;
      state_next.byte_shift  = '0;
      result.direction       = state_next.current_direction;
    end else if (state.bit_counter == pwsd_pkg::LAST_BIT) begin
      // Eighth bit completes the byte.
      result.byte_value      = byte_merged;
      state_next.bit_counter = '0;
      state_next.byte_shift  = '0;
    end else begin
      // Data bit inside a byte: no result yet.
      result.valid           = 1'b0;
      state_next.bit_counter = state.bit_counter + 1'b1;
      state_next.byte_shift  = byte_merged;
    end
  end

endmodule

[hdl/pulse_width_serial_decoder.sv]
// ----------------------------------------------------------------------------
// pulse_width_serial_decoder
// Decodes a pulse-width coded serial line from measured clock pulses.
// ----------------------------------------------------------------------------
// The block takes one pulse item per clock cycle and keeps that rate without
// gaps as long as results are taken. An item passes an input register, is
// decoded by one compare chain and bit merge, and its result (if any) is held
// in a result register, so a result reaches the outputs once its item has
// passed both registers. Framing pulses always give a result; data bits
// give one on every eighth bit. While a result waits in the result register,
// one more item is still accepted into the input register; that item then
// waits there, and the input stalls, until the result is taken. Configuration
// writes take effect at once and should only be made while no item is in
// flight.
module pulse_width_serial_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_en,
  input  logic [pwsd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pwsd_pkg::CfgDataW-1:0]     cfg_data,
  // Pulse items.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pwsd_pkg::LenW-1:0]         pulse_length,
  input  logic                              data_bit,
  // Result items.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pwsd_pkg::KindW-1:0]        frame_kind,
  output logic [pwsd_pkg::ByteW-1:0]        byte_value,
  output logic [pwsd_pkg::DirW-1:0]         direction
);

  pwsd_pkg::cfg_t    cfg;
  pwsd_pkg::state_t  state;
  pwsd_pkg::state_t  state_next;
  pwsd_pkg::result_t result;

  logic                        in_held;
  logic [pwsd_pkg::LenW-1:0]   len_q;
  logic                        bit_q;
  logic                        advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit        <= pwsd_pkg::TIMEOUT_RESET;
      cfg.sync_limit           <= pwsd_pkg::SYNC_RESET;
      cfg.outbound_start_limit <= pwsd_pkg::OUT_START_RESET;
      cfg.inbound_start_limit  <= pwsd_pkg::IN_START_RESET;
      cfg.msb_first            <= pwsd_pkg::MSB_FIRST_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        pwsd_pkg::REG_TIMEOUT:   cfg.timeout_limit        <= cfg_data;
        pwsd_pkg::REG_SYNC:      cfg.sync_limit           <= cfg_data;
        pwsd_pkg::REG_OUT_START: cfg.outbound_start_limit <= cfg_data;
        pwsd_pkg::REG_IN_START:  cfg.inbound_start_limit  <= cfg_data;
        pwsd_pkg::REG_MSB_FIRST: cfg.msb_first            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held item is decoded when the result register can take its result.
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      len_q <= pulse_length;
      bit_q <= data_bit;
    end
  end

  pwsd_decode u_decode (
    .cfg          (cfg),
    .state        (state),
    .pulse_length (len_q),
    .data_bit     (bit_q),
    .state_next   (state_next),
    .result       (result)
  );

  // Decoder state advances once per decoded item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.bit_counter       <= '0;
      state.byte_shift        <= '0;
      state.current_direction <= pwsd_pkg::DIR_UNKNOWN;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      frame_kind <= result.frame_kind;
      byte_value <= result.byte_value;
      direction  <= result.direction;
    end
  end

endmodule

[hdl/pwsd_checker.sv]
// ----------------------------------------------------------------------------
// pwsd_checker
// Port-level checks on the result channel of the pulse width serial decoder.
// ----------------------------------------------------------------------------
module pwsd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pwsd_pkg::KindW-1:0]    frame_kind,
  input logic [pwsd_pkg::ByteW-1:0]    byte_value,
  input logic [pwsd_pkg::DirW-1:0]     direction
);

  // A stalled result item holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) &&
      $stable(byte_value) && $stable(direction))
    else $error("result item changed while stalled");

  // Only data items carry a byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != pwsd_pkg::KIND_DATA |-> byte_value == '0)
    else $error("non-data item carries a byte");

  // Error and sync leave the direction unknown.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == pwsd_pkg::KIND_ERROR ||
      frame_kind == pwsd_pkg::KIND_SYNC) |-> direction == pwsd_pkg::DIR_UNKNOWN)
    else $error("error or sync item with a known direction");

  // Start items report the direction they set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == pwsd_pkg::KIND_OUT_START |->
      direction == pwsd_pkg::DIR_OUT)
    else $error("outbound start without outbound direction");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == pwsd_pkg::KIND_IN_START |->
      direction == pwsd_pkg::DIR_IN)
    else $error("inbound start without inbound direction");

endmodule

bind pulse_width_serial_decoder pwsd_checker u_pwsd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_kind (frame_kind),
  .byte_value (byte_value),
  .direction  (direction)
);

[bench/decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame checker for the pulse width serial decoder
// Watches the configuration port and both item channels. Keeps its own copy
// of the limits and of the bit assembly state, works out the frame that each
// accepted pulse should give, and compares every frame leaving the decoder
// with the oldest one still due.
// ----------------------------------------------------------------------------
module decoder_checker
  import pwsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [LenW-1:0]     pulse_length,
  input  logic                data_bit,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [KindW-1:0]    frame_kind,
  input  logic [ByteW-1:0]    byte_value,
  input  logic [DirW-1:0]     direction,
  output int                  fail_count,
  output int                  frames_pending
);

  // One decoded frame as it leaves the block.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic [DirW-1:0]  dir;
  } frame_t;

  localparam int ReportLimit = 10;

  cfg_t              limits;
  logic [CountW-1:0] bits_taken;
  logic [ByteW-1:0]  partial_byte;
  logic [DirW-1:0]   link_dir;
  frame_t            frames_due[$];

  // Classifies one pulse and updates the assembly state. Returns 1 when the
  // pulse completes a frame.
  function automatic logic decode_pulse(input logic [LenW-1:0] len, input logic level,
                                        output frame_t frame);
    frame = '0;
    if (len > limits.timeout_limit) begin
      frame.kind = KIND_ERROR;
      link_dir = DIR_UNKNOWN;
    end else if (len > limits.sync_limit) begin
      frame.kind = KIND_SYNC;
      link_dir = DIR_UNKNOWN;
    end else if (len > limits.outbound_start_limit) begin
      frame.kind = KIND_OUT_START;
      link_dir = DIR_OUT;
    end else if (len > limits.inbound_start_limit) begin
      frame.kind = KIND_IN_START;
      link_dir = DIR_IN;
    end else begin
      // Data bit: set its position, then count it.
      if (level) begin
        if (limits.msb_first) begin
          partial_byte[LAST_BIT - bits_taken] = 1'b1;
        end else begin
          partial_byte[bits_taken] = 1'b1;
        end
      end
      if (bits_taken == LAST_BIT) begin
        frame.kind = KIND_DATA;
        frame.value = partial_byte;
        frame.dir = link_dir;
        bits_taken = '0;
        partial_byte = '0;
        return 1'b1;
      end
      bits_taken = bits_taken + 1'b1;
      return 1'b0;
    end
    // Every framing pulse drops a partly assembled byte.
    bits_taken = '0;
    partial_byte = '0;
    frame.dir = link_dir;
    return 1'b1;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    frame_t fresh;
    if (rst) begin
      limits.timeout_limit = TIMEOUT_RESET;
      limits.sync_limit = SYNC_RESET;
      limits.outbound_start_limit = OUT_START_RESET;
      limits.inbound_start_limit = IN_START_RESET;
      limits.msb_first = MSB_FIRST_RESET;
      bits_taken = '0;
      partial_byte = '0;
      link_dir = DIR_UNKNOWN;
      frames_due.delete();
      fail_count = 0;
    end else begin
      // Register writes; indexes past the last register are ignored.
      if (cfg_en) begin
        case (cfg_index)
          REG_TIMEOUT: begin
            limits.timeout_limit = cfg_data;
          end
          REG_SYNC: begin
            limits.sync_limit = cfg_data;
          end
          REG_OUT_START: begin
            limits.outbound_start_limit = cfg_data;
          end
          REG_IN_START: begin
            limits.inbound_start_limit = cfg_data;
          end
          REG_MSB_FIRST: begin
            limits.msb_first = cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      // Frames leaving the block are matched against the oldest one due.
      if (out_valid && out_ready) begin
        got = '{frame_kind, byte_value, direction};
        if (frames_due.size() == 0) begin
          note_failure($sformatf("unexpected frame: kind %0d byte 0x%02h dir %0d",
                                 got.kind, got.value, got.dir));
        end else begin
          want = frames_due.pop_front();
          if (got.kind !== want.kind || got.value !== want.value || got.dir !== want.dir) begin
            note_failure($sformatf({"frame mismatch: expected kind %0d byte 0x%02h dir %0d,",
                                    " got kind %0d byte 0x%02h dir %0d"},
                                   want.kind, want.value, want.dir,
                                   got.kind, got.value, got.dir));
          end
        end
      end

      // Pulses entering the block.
      if (in_valid && in_ready) begin
        if (decode_pulse(pulse_length, data_bit, fresh)) begin
          frames_due.push_back(fresh);
        end
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width serial decoder testbench
// Drives pulse items under random idle gaps and result stalls through a set
// of limit settings, from the reset values to the extremes and to limits out
// of order. A directed opening covers every frame kind and the boundaries of
// each limit; random transfers follow, mostly a start pulse and whole bytes,
// with broken bytes and noise pulses mixed in. The checker beside the decoder
// does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import pwsd_pkg::*;

  localparam int          CycleLimit     = 1000000;
  localparam int          PhaseCount     = 8;
  localparam int          ItemsPerPhase  = 232;
  localparam int          SettleCycles   = 4;
  localparam int          DrainCycles    = 8;
  localparam int unsigned LenMax         = (1 << LenW) - 1;
  localparam int          RandomLen      = -1;

  logic                clk;
  logic                rst;
  logic                cfg_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [LenW-1:0]     pulse_length;
  logic                data_bit;
  logic                out_valid;
  logic                out_ready;
  logic [KindW-1:0]    frame_kind;
  logic [ByteW-1:0]    byte_value;
  logic [DirW-1:0]     direction;

  int fail_count;
  int frames_pending;
  int cycle_count;
  int items_sent;
  bit calm;

  // Limits as last written, used to aim pulse lengths at each frame kind.
  int unsigned timeout_lim;
  int unsigned sync_lim;
  int unsigned out_lim;
  int unsigned in_lim;

  pulse_width_serial_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pulse_length (pulse_length),
    .data_bit     (data_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_kind   (frame_kind),
    .byte_value   (byte_value),
    .direction    (direction)
  );

  decoder_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pulse_length   (pulse_length),
    .data_bit       (data_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_kind     (frame_kind),
    .byte_value     (byte_value),
    .direction      (direction),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle cycles before an item: mostly none or a few, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(3, 1);
    end else if (roll < 98) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Result stalls: runs of ready and of stall, the stalls with the same mix of lengths.
  initial begin
    int run;
    out_ready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready = 1'b1;
        run = 0;
      end else if (run == 0) begin
        out_ready = ~out_ready;
        run = out_ready ? $urandom_range(8, 1) : pick_gap() + 1;
      end else begin
        run--;
      end
    end
  end

  // A length in [lo, hi], often on an edge; any length if the range is empty.
  function automatic logic [LenW-1:0] pick_in(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    if (lo > hi) begin
      return LenW'($urandom());
    end
    roll = $urandom_range(9);
    if (roll == 0) begin
      return LenW'(lo);
    end else if (roll == 1) begin
      return LenW'(hi);
    end
    return LenW'($urandom_range(hi, lo));
  endfunction

  // A pulse length that gives the wanted frame kind under ordered limits.
  function automatic logic [LenW-1:0] frame_length(input logic [KindW-1:0] kind);
    int unsigned floor_lim;
    floor_lim = timeout_lim;
    if (sync_lim < floor_lim) floor_lim = sync_lim;
    if (out_lim < floor_lim) floor_lim = out_lim;
    if (in_lim < floor_lim) floor_lim = in_lim;
    case (kind)
      KIND_ERROR:     return pick_in(timeout_lim + 1, LenMax);
      KIND_SYNC:      return pick_in(sync_lim + 1, timeout_lim);
      KIND_OUT_START: return pick_in(out_lim + 1, sync_lim);
      KIND_IN_START:  return pick_in(in_lim + 1, out_lim);
      default:        return pick_in(0, floor_lim);
    endcase
  endfunction

  // Offers one pulse item and returns at the falling edge after it is taken.
  task automatic push(input logic [LenW-1:0] len, input logic level);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pulse_length = len;
    data_bit = level;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends data bits taken from the top of pattern down.
  task automatic send_bits(input logic [7:0] pattern, input int count, input int len_sel);
    for (int k = 0; k < count; k++) begin
      push((len_sel < 0) ? frame_length(KIND_DATA) : len_sel[LenW-1:0], pattern[7 - k]);
    end
  endtask

  // One register write on the configuration port.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_en = 1'b0;
    case (idx)
      REG_TIMEOUT:   timeout_lim = 32'(value);
      REG_SYNC:      sync_lim = 32'(value);
      REG_OUT_START: out_lim = 32'(value);
      REG_IN_START:  in_lim = 32'(value);
      default: begin
      end
    endcase
  endtask

  // Holds input back until every frame is out and the pipeline has emptied.
  task automatic settle();
    in_valid = 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Writes every register for one phase, plus a write past the last index.
  task automatic configure_phase(input int phase);
    int unsigned t;
    int unsigned s;
    int unsigned o;
    int unsigned i;
    logic [CfgDataW-1:0] order_word;
    order_word = CfgDataW'($urandom());
    case (phase)
      0: begin
        t = 32'(TIMEOUT_RESET); s = 32'(SYNC_RESET);
        o = 32'(OUT_START_RESET); i = 32'(IN_START_RESET);
        order_word = 24'hFFFFFE;
      end
      1: begin
        t = 0; s = 0; o = 0; i = 0;
        order_word = 24'h000001;
      end
      2: begin
        t = LenMax; s = LenMax; o = LenMax; i = LenMax;
        order_word = 24'h000000;
      end
      3: begin
        t = 3; s = 2; o = 1; i = 0;
        order_word = 24'hAAAAAB;
      end
      4: begin
        i = $urandom_range(2000);
        o = i + $urandom_range(2000);
        s = o + $urandom_range(2000);
        t = s + $urandom_range(2000);
      end
      5: begin
        // Limits in no particular order.
        t = $urandom_range(4000); s = $urandom_range(4000);
        o = $urandom_range(4000); i = $urandom_range(4000);
      end
      6: begin
        t = LenMax; s = LenMax - 1; o = LenMax - 2; i = LenMax - 3;
      end
      default: begin
        t = 32'(TIMEOUT_RESET); s = 32'(SYNC_RESET);
        o = 32'(OUT_START_RESET); i = 32'(IN_START_RESET);
        order_word = {23'h7FFFFF, MSB_FIRST_RESET};
      end
    endcase
    write_reg(REG_TIMEOUT, CfgDataW'(t));
    write_reg(REG_SYNC, CfgDataW'(s));
    write_reg(REG_OUT_START, CfgDataW'(o));
    write_reg(REG_IN_START, CfgDataW'(i));
    write_reg(REG_MSB_FIRST, order_word);
    write_reg(REG_MSB_FIRST + CfgIdxW'($urandom_range(3, 1)), CfgDataW'($urandom()));
  endtask

  // A typical transfer: a start pulse, whole bytes, sometimes a broken byte
  // and a stray framing or noise pulse at the end.
  task automatic run_transfer();
    int unsigned roll;
    if ($urandom_range(15) == 0) calm = !calm;
    roll = $urandom_range(99);
    if (roll < 45) begin
      push(frame_length(KIND_IN_START), 1'($urandom_range(1)));
    end else if (roll < 90) begin
      push(frame_length(KIND_OUT_START), 1'($urandom_range(1)));
    end
    repeat ($urandom_range(4, 1)) send_bits(8'($urandom()), 8, RandomLen);
    if ($urandom_range(99) < 20) begin
      send_bits(8'($urandom()), $urandom_range(7, 1), RandomLen);
    end
    roll = $urandom_range(99);
    if (roll < 10) begin
      push(frame_length(KIND_SYNC), 1'($urandom_range(1)));
    end else if (roll < 16) begin
      push(frame_length(KIND_ERROR), 1'($urandom_range(1)));
    end else if (roll < 24) begin
      push(LenW'($urandom()), 1'($urandom_range(1)));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int phase_start;
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pulse_length = '0;
    data_bit = 1'b0;
    cycle_count = 0;
    items_sent = 0;
    calm = 1'b0;
    timeout_lim = 32'(TIMEOUT_RESET);
    sync_lim = 32'(SYNC_RESET);
    out_lim = 32'(OUT_START_RESET);
    in_lim = 32'(IN_START_RESET);
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed opening under the reset limits. A byte before any start
    // carries an unknown direction; lengths sit just past each limit and on all but the sync limit.
    send_bits(8'hB2, 8, int'(IN_START_RESET));
    push(IN_START_RESET + 24'd1, 1'b1);
    push(OUT_START_RESET + 24'd1, 1'b0);
    push(OUT_START_RESET, 1'b1);
    push(SYNC_RESET + 24'd1, 1'b0);
    push(TIMEOUT_RESET, 1'b1);
    push(TIMEOUT_RESET + 24'd1, 1'b0);
    push(LenW'(LenMax), 1'b1);
    // A broken byte is dropped by the next start.
    send_bits(8'hE0, 3, 0);
    push(OUT_START_RESET + 24'd1, 1'b0);
    send_bits(8'hFF, 8, 0);

    // Random transfers through each limit setting.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      configure_phase(phase);
      phase_start = items_sent;
      while (items_sent - phase_start < ItemsPerPhase) run_transfer();
    end

    in_valid = 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pwsd_pkg.sv
hdl/pwsd_decode.sv
hdl/pulse_width_serial_decoder.sv
hdl/pwsd_checker.sv
bench/decoder_checker.sv
bench/testbench.sv
